/* rtl/crw_pkg.sv */
// shared types and constants for the command response waiter
`default_nettype none

package crw_pkg;

	// default reply buffer size in bytes
	localparam int unsigned REPLY_BUFFER_SIZE_DEF = 64;

	// stream payload widths
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned STATUS_W   = 2;

	// tick counter widths
	localparam int unsigned ELAPSED_W = 17;
	localparam int unsigned ALLOWED_W = 16;
	localparam int unsigned MAG_W     = 15;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'h7fff;

	// opcodes
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd3;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_O     = 8'h6f;
	localparam logic [7:0] CH_K     = 8'h6b;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// line matcher phase
	typedef enum logic [3:0] {
		PH_START,
		PH_O,
		PH_OK,
		PH_E,
		PH_ER,
		PH_ERR,
		PH_ERRO,
		PH_ERROR,
		PH_BLANK,
		PH_NUM,
		PH_DONE,
		PH_OTHER
	} line_phase_t;

endpackage

`default_nettype wire

/* rtl/command_response_waiter.sv */
// top level: waits for a controller reply and reports ok, error code, overflow or timeout
// flow: a word taken into the input register is processed once the result register is free,
// and a result that it yields is written to the result register and offered on the master side
// throughput: one word per cycle while m_tready holds; an empty input register still takes
// a new word while a finished result waits for m_tready in the result register
// reset: arst_n clears the handshake valids and all wait state, the block comes up idle
`default_nettype none

module command_response_waiter #(
	parameter int unsigned REPLY_BUFFER_SIZE = crw_pkg::REPLY_BUFFER_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [7:0] data_byte, [23:8] timeout_ticks
	input  wire logic [crw_pkg::IN_DATA_W-1:0] s_tdata,
	// [1:0] opcode
	input  wire logic [crw_pkg::OP_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [15:0] error_code
	output logic [crw_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [1:0] status
	output logic [crw_pkg::STATUS_W-1:0]       m_tuser
);
	import crw_pkg::*;

	localparam int unsigned CNT_W = $clog2(REPLY_BUFFER_SIZE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REPLY_BUFFER_SIZE - 1);
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// input stage
	logic                 valid_s1;
	logic [OP_W-1:0]      op_s1;
	logic [7:0]           byte_s1;
	logic [ALLOWED_W-1:0] ticks_s1;

	// wait state
	logic                 waiting_q;
	logic [CNT_W-1:0]     byte_count_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [ALLOWED_W-1:0] allowed_q;
	line_phase_t          phase_q;
	logic                 neg_q;
	logic [MAG_W-1:0]     mag_q;

	// result register
	logic                  m_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [OUT_DATA_W-1:0] code_q;

	logic out_free;
	logic fire;

	// matcher next values for one ordinary byte
	line_phase_t      phase_adv;
	logic             neg_adv;
	logic [MAG_W-1:0] mag_adv;
	logic             is_digit;
	logic             is_blank;
	logic [MAG_W+3:0] mag_x10;

	// event results
	logic                  emit;
	logic [STATUS_W-1:0]   emit_status;
	logic [OUT_DATA_W-1:0] emit_code;
	logic                  is_eol;
	logic [ELAPSED_W-1:0]  elapsed_inc;

	// next state
	logic                 waiting_d;
	logic [CNT_W-1:0]     byte_count_d;
	logic [ELAPSED_W-1:0] elapsed_d;
	logic [ALLOWED_W-1:0] allowed_d;
	line_phase_t          phase_d;
	logic                 neg_d;
	logic [MAG_W-1:0]     mag_d;

	// handshake
	assign out_free = !m_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			byte_s1  <= s_tdata[7:0];
			ticks_s1 <= s_tdata[23:8];
		end
	end

	// digit accumulate with saturation
	assign is_digit = byte_s1 inside {[CH_ZERO:CH_NINE]};
	assign is_blank = byte_s1 inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
	assign mag_x10  = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
		+ {15'b0, byte_s1[3:0]};

	// line matcher next state
	always_comb begin
		phase_adv = phase_q;
		neg_adv   = neg_q;
		mag_adv   = mag_q;
		case (phase_q)
			PH_START: begin
				if (byte_s1 == CH_O) begin
					phase_adv = PH_O;
				end else if (byte_s1 == CH_E) begin
					phase_adv = PH_E;
				end else begin
					phase_adv = PH_OTHER;
				end
			end
			PH_O:     phase_adv = (byte_s1 == CH_K) ? PH_OK : PH_OTHER;
			PH_OK, PH_DONE, PH_OTHER: phase_adv = phase_q;
			PH_E:     phase_adv = (byte_s1 == CH_R) ? PH_ER : PH_OTHER;
			PH_ER:    phase_adv = (byte_s1 == CH_R) ? PH_ERR : PH_OTHER;
			PH_ERR:   phase_adv = (byte_s1 == CH_O) ? PH_ERRO : PH_OTHER;
			PH_ERRO:  phase_adv = (byte_s1 == CH_R) ? PH_ERROR : PH_OTHER;
			PH_ERROR: phase_adv = (byte_s1 == CH_COLON) ? PH_BLANK : PH_OTHER;
			PH_BLANK: begin
				if (is_blank) begin
					phase_adv = PH_BLANK;
				end else if (byte_s1 == CH_MINUS || byte_s1 == CH_PLUS) begin
					neg_adv   = (byte_s1 == CH_MINUS);
					phase_adv = PH_NUM;
				end else if (is_digit) begin
					mag_adv   = (mag_x10 > {4'b0, MAG_MAX}) ? MAG_MAX : mag_x10[MAG_W-1:0];
					phase_adv = PH_NUM;
				end else begin
					phase_adv = PH_DONE;
				end
			end
			PH_NUM: begin
				if (is_digit) begin
					mag_adv = (mag_x10 > {4'b0, MAG_MAX}) ? MAG_MAX : mag_x10[MAG_W-1:0];
				end else begin
					phase_adv = PH_DONE;
				end
			end
			default:  phase_adv = PH_OTHER;
		endcase
	end

	// result of the word in the input stage
	assign is_eol      = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_code   = '0;
		if (waiting_q) begin
			case (op_s1)
				OP_BYTE: begin
					if (byte_count_q >= CNT_LAST) begin
						emit        = 1'b1;
						emit_status = ST_OVERFLOW;
					end else if (is_eol && phase_q == PH_OK) begin
						emit        = 1'b1;
						emit_status = ST_OK;
					end else if (is_eol && (phase_q == PH_BLANK || phase_q == PH_NUM
							|| phase_q == PH_DONE)) begin
						emit        = 1'b1;
						emit_status = ST_ERROR;
						emit_code   = neg_q ? (16'd0 - {1'b0, mag_q}) : {1'b0, mag_q};
					end
				end
				OP_TICK: begin
					if (elapsed_inc > {1'b0, allowed_q}) begin
						emit        = 1'b1;
						emit_status = ST_TIMEOUT;
					end
				end
				default: emit = 1'b0;
			endcase
		end
	end

	// wait state next values
	always_comb begin
		waiting_d    = waiting_q;
		byte_count_d = byte_count_q;
		elapsed_d    = elapsed_q;
		allowed_d    = allowed_q;
		phase_d      = phase_q;
		neg_d        = neg_q;
		mag_d        = mag_q;
		if (emit) begin
			waiting_d    = 1'b0;
			byte_count_d = '0;
			elapsed_d    = '0;
			allowed_d    = '0;
			phase_d      = PH_START;
			neg_d        = 1'b0;
			mag_d        = '0;
		end else begin
			case (op_s1)
				OP_START: begin
					if (!waiting_q) begin
						waiting_d    = 1'b1;
						byte_count_d = '0;
						elapsed_d    = '0;
						allowed_d    = ticks_s1;
						phase_d      = PH_START;
						neg_d        = 1'b0;
						mag_d        = '0;
					end
				end
				OP_BYTE: begin
					if (waiting_q) begin
						byte_count_d = byte_count_q + 1'b1;
						if (is_eol) begin
							phase_d = PH_START;
							neg_d   = 1'b0;
							mag_d   = '0;
						end else begin
							phase_d = phase_adv;
							neg_d   = neg_adv;
							mag_d   = mag_adv;
						end
					end
				end
				OP_TICK: begin
					if (waiting_q) begin
						elapsed_d = elapsed_inc;
					end
				end
				default: waiting_d = waiting_q;
			endcase
		end
	end

	// wait state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q    <= 1'b0;
			byte_count_q <= '0;
			elapsed_q    <= '0;
			allowed_q    <= '0;
			phase_q      <= PH_START;
			neg_q        <= 1'b0;
			mag_q        <= '0;
		end else if (fire) begin
			waiting_q    <= waiting_d;
			byte_count_q <= byte_count_d;
			elapsed_q    <= elapsed_d;
			allowed_q    <= allowed_d;
			phase_q      <= phase_d;
			neg_q        <= neg_d;
			mag_q        <= mag_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			status_q <= emit_status;
			code_q   <= emit_code;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = code_q;
	assign m_tuser  = status_q;

endmodule

`default_nettype wire

/* rtl/crw_checker.sv */
// port checker for the command response waiter and its bind
`default_nettype none

module crw_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [crw_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [crw_pkg::STATUS_W-1:0]   m_tuser
);
	import crw_pkg::*;

	logic in_word;
	assign in_word = s_tvalid && s_tready;

	// a pending result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// only an error line carries a code
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_ERROR |-> m_tdata == '0)
		else $error("nonzero code on a non-error status");

	// a fresh result traces back to an accepted word that passed through the input register
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_word, 2))
		else $error("result word without an accepted input word");

endmodule

bind command_response_waiter crw_checker u_crw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the command response waiter: directed replies, then random sessions
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import crw_pkg::*;

	localparam int BUF_SIZE      = REPLY_BUFFER_SIZE_DEF;
	localparam int ELAPSED_LIMIT = (1 << ELAPSED_W) - 1;
	localparam int RANDOM_WORDS  = 750;
	localparam int QUIET_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 8;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [15:0]         code;
	} reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	// replies the block owes, oldest first
	reply_t awaited_replies[$];

	// mirror of the wait state
	bit          rx_waiting;
	int          rx_count;
	int          ticks_elapsed;
	int          ticks_allowed;
	line_phase_t phase;
	bit          code_neg;
	int          code_mag;

	int send_gap_max = 5;
	int reply_stall_max = 5;
	int reply_stall_left = 0;
	int mismatch_count = 0;
	int effective_words = 0;
	int quiet_cycles = 0;

	command_response_waiter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_line();
		phase    = PH_START;
		code_neg = 1'b0;
		code_mag = 0;
	endfunction

	function automatic void reset_session();
		rx_waiting    = 1'b0;
		rx_count      = 0;
		ticks_elapsed = 0;
		ticks_allowed = 0;
		clear_line();
	endfunction

	function automatic void take_digit(input logic [7:0] data);
		code_mag = code_mag * 10 + int'(data - CH_ZERO);
		if (code_mag > int'(MAG_MAX)) begin
			code_mag = int'(MAG_MAX);
		end
	endfunction

	function automatic void finish_session(input logic [STATUS_W-1:0] status,
			input logic [15:0] code);
		reply_t r;
		r.status = status;
		r.code   = code;
		awaited_replies.push_back(r);
		reset_session();
	endfunction

	// advance the mirror by one word, queue its reply; returns 0 when the word is ignored
	function automatic bit predict_reply(input logic [OP_W-1:0] op, input logic [7:0] data,
			input logic [15:0] ticks);
		bit          is_digit;
		logic [15:0] code;
		if (op == OP_START) begin
			if (rx_waiting) begin
				return 1'b0;
			end
			reset_session();
			rx_waiting    = 1'b1;
			ticks_allowed = int'(ticks);
			return 1'b1;
		end
		if (!rx_waiting || (op != OP_BYTE && op != OP_TICK)) begin
			return 1'b0;
		end
		if (op == OP_TICK) begin
			if (ticks_elapsed < ELAPSED_LIMIT) begin
				ticks_elapsed++;
			end
			if (ticks_elapsed > ticks_allowed) begin
				finish_session(ST_TIMEOUT, 16'd0);
			end
			return 1'b1;
		end
		// byte: the buffer keeps one slot free
		if (rx_count >= BUF_SIZE - 1) begin
			finish_session(ST_OVERFLOW, 16'd0);
			return 1'b1;
		end
		rx_count++;
		if (data == CH_CR || data == CH_LF) begin
			if (phase == PH_OK) begin
				finish_session(ST_OK, 16'd0);
			end else if (phase inside {PH_BLANK, PH_NUM, PH_DONE}) begin
				code = 16'(code_mag);
				if (code_neg) begin
					code = -code;
				end
				finish_session(ST_ERROR, code);
			end else begin
				clear_line();
			end
			return 1'b1;
		end
		// line matcher
		is_digit = (data >= CH_ZERO && data <= CH_NINE);
		case (phase)
			PH_START: phase = (data == CH_O) ? PH_O : (data == CH_E) ? PH_E : PH_OTHER;
			PH_O:     phase = (data == CH_K) ? PH_OK : PH_OTHER;
			PH_E:     phase = (data == CH_R) ? PH_ER : PH_OTHER;
			PH_ER:    phase = (data == CH_R) ? PH_ERR : PH_OTHER;
			PH_ERR:   phase = (data == CH_O) ? PH_ERRO : PH_OTHER;
			PH_ERRO:  phase = (data == CH_R) ? PH_ERROR : PH_OTHER;
			PH_ERROR: phase = (data == CH_COLON) ? PH_BLANK : PH_OTHER;
			PH_BLANK: begin
				if (data == CH_SPACE || data == CH_TAB || data == CH_VT || data == CH_FF) begin
					phase = PH_BLANK;
				end else if (data == CH_MINUS || data == CH_PLUS) begin
					code_neg = (data == CH_MINUS);
					phase    = PH_NUM;
				end else if (is_digit) begin
					take_digit(data);
					phase = PH_NUM;
				end else begin
					phase = PH_DONE;
				end
			end
			PH_NUM: begin
				if (is_digit) begin
					take_digit(data);
				end else begin
					phase = PH_DONE;
				end
			end
			default: phase = phase;
		endcase
		return 1'b1;
	endfunction

	// send one word after a random gap, update the mirror when it is taken
	task automatic send_word(input logic [OP_W-1:0] op, input logic [7:0] data,
			input logic [15:0] ticks);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {ticks, data};
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (predict_reply(op, data, ticks)) begin
			effective_words++;
		end
	endtask

	// reply byte, sometimes preceded by a tick; nothing once the session is over
	task automatic send_reply_byte(input logic [7:0] data, input int tick_pct);
		if (rx_waiting && $urandom_range(0, 99) < tick_pct) begin
			send_word(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom));
		end
		if (rx_waiting) begin
			send_word(OP_BYTE, data, 16'($urandom));
		end
	endtask

	task automatic send_text(input string text, input int tick_pct);
		for (int i = 0; i < text.len(); i++) begin
			send_reply_byte(8'(text[i]), tick_pct);
		end
	endtask

	task automatic send_start(input logic [15:0] budget);
		send_word(OP_START, 8'($urandom_range(0, 255)), budget);
	endtask

	// hold the sender until every owed reply is out
	task automatic wait_replies_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// bytes, ticks and an unused opcode while idle are dropped
	task automatic test_idle_words();
		send_word(OP_TICK, 8'h00, 16'h0000);
		send_word(OP_BYTE, 8'hff, 16'hffff);
		send_word(2'd3, 8'hff, 16'hffff);
	endtask

	// zero and one tick budgets, a restart while waiting is ignored
	task automatic test_tick_timeout();
		send_start(16'd0);
		send_start(16'hffff);
		send_word(OP_TICK, 8'h00, 16'h0000);
		send_start(16'd1);
		send_word(OP_TICK, 8'h00, 16'h0000);
		send_word(OP_TICK, 8'h00, 16'h0000);
	endtask

	task automatic test_ok_line();
		send_start(16'hffff);
		send_text("ok\r", 0);
	endtask

	// blanks, sign and a magnitude that saturates
	task automatic test_error_line();
		send_start(16'hffff);
		send_text("error:", 0);
		send_reply_byte(CH_VT, 0);
		send_text(" -99999\n", 0);
	endtask

	// error line that ends before any digit
	task automatic test_empty_code();
		send_start(16'h8000);
		send_text("error:\r", 0);
	endtask

	// discarded line still fills the buffer, then the overflow byte
	task automatic test_overflow();
		send_start(16'hffff);
		send_text("abc\n", 0);
		while (rx_waiting) begin
			send_word(OP_BYTE, 8'h78, 16'h0000);
		end
	endtask

	// one armed session: a few lines of varied shape, then a forced end
	task automatic run_session();
		logic [15:0] budget;
		int          tick_pct;
		int          cut;
		string       prefix;
		case ($urandom_range(0, 3))
			0:       budget = 16'($urandom_range(0, 3));
			1, 2:    budget = 16'($urandom_range(4, 60));
			default: budget = 16'($urandom);
		endcase
		send_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 5;
		reply_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
		tick_pct        = $urandom_range(0, 25);
		send_start(budget);
		if ($urandom_range(0, 9) == 0) begin
			send_start(16'($urandom));
		end
		repeat ($urandom_range(1, 4)) begin
			if (!rx_waiting) begin
				break;
			end
			case ($urandom_range(0, 5))
				0: begin
					send_text("ok", tick_pct);
					repeat ($urandom_range(0, 3)) begin
						send_reply_byte(8'($urandom_range(0, 255)), tick_pct);
					end
				end
				1, 2: begin
					send_text("error:", tick_pct);
					repeat ($urandom_range(0, 2)) begin
						case ($urandom_range(0, 3))
							0:       send_reply_byte(CH_SPACE, tick_pct);
							1:       send_reply_byte(CH_TAB, tick_pct);
							2:       send_reply_byte(CH_VT, tick_pct);
							default: send_reply_byte(CH_FF, tick_pct);
						endcase
					end
					case ($urandom_range(0, 2))
						0:       send_reply_byte(CH_PLUS, tick_pct);
						1:       send_reply_byte(CH_MINUS, tick_pct);
						default: ;
					endcase
					repeat ($urandom_range(0, 6)) begin
						send_reply_byte(CH_ZERO + 8'($urandom_range(0, 9)), tick_pct);
					end
					if ($urandom_range(0, 2) == 0) begin
						send_reply_byte(8'($urandom_range(0, 255)), tick_pct);
					end
				end
				3: begin
					// broken keyword
					if ($urandom_range(0, 3) == 0) begin
						prefix = "ok";
					end else begin
						prefix = "error:";
					end
					cut = $urandom_range(1, prefix.len() - 1);
					send_text(prefix.substr(0, cut - 1), tick_pct);
					send_reply_byte(8'($urandom_range(0, 255)), tick_pct);
				end
				default: begin
					repeat ($urandom_range(1, 8)) begin
						send_reply_byte(8'($urandom_range(0, 255)), tick_pct);
					end
				end
			endcase
			send_reply_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF, tick_pct);
		end
		// close a session that is still open
		if (rx_waiting) begin
			if (ticks_allowed <= 60 && $urandom_range(0, 1) == 0) begin
				while (rx_waiting) begin
					send_word(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom));
				end
			end else if ($urandom_range(0, 1) == 0) begin
				while (rx_waiting) begin
					send_word(OP_BYTE, 8'($urandom_range(0, 255)), 16'($urandom));
				end
			end else begin
				send_text("ok\n", 0);
			end
		end
	endtask

	task automatic test_random_sessions();
		int sessions;
		sessions = 0;
		while (effective_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0) begin
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					16'($urandom));
			end
			run_session();
			sessions++;
			if (sessions % 20 == 0) begin
				wait_replies_drained();
			end
		end
	endtask

	// receiver stall, counted down only while a word is offered
	always @(negedge clk) begin
		if (reply_stall_left > 0) begin
			m_tready <= 1'b0;
			if (m_tvalid) begin
				reply_stall_left <= reply_stall_left - 1;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	// reply checker
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			reply_stall_left <= $urandom_range(0, reply_stall_max);
			if (awaited_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected reply: status %0d code %0d", m_tuser,
						$signed(m_tdata));
				end
			end else begin
				want = awaited_replies.pop_front();
				if (m_tuser !== want.status || m_tdata !== want.code) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected status %0d code %0d, got %0d code %0d",
							want.status, $signed(want.code), m_tuser, $signed(m_tdata));
					end
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// test sequence
	initial begin
		reset_session();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_words();
		test_tick_timeout();
		wait_replies_drained();
		test_ok_line();
		test_error_line();
		test_empty_code();
		test_overflow();
		wait_replies_drained();
		test_random_sessions();
		wait_replies_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_replies.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* command_response_waiter.f */
rtl/crw_pkg.sv
rtl/command_response_waiter.sv
rtl/crw_checker.sv
tb/testbench.sv
